FILE: design/mbd_pkg.sv
// shared types, register codes and table-building functions for the mipmap box downsampler
// no dependencies; imported by mbd_cfg, mbd_combine and the top level
package mbd_pkg;

  localparam int MBD_MAX_DIM     = 4096;
  localparam int MBD_LINEAR_BITS = 16;
  localparam int MBD_ADDR_W      = 4;

  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_SRGB   = 2'd2;

  localparam logic [63:0] Q31_ONE = 64'd2147483648;
  localparam logic [63:0] B_SQ    = 64'd2894978025;

  typedef struct packed {
    logic [12:0] width;
    logic [12:0] height;
    logic        srgb;
    logic        clear;
  } mbd_cfg_t;

  // srgb decode of n/510 in q31
  function automatic logic [63:0] mbd_decode_q31(input int unsigned n_in);
    logic [63:0] n;
    logic [63:0] a;
    logic [63:0] u2;
    logic [63:0] r;
    logic [63:0] c;
    logic [63:0] p2;
    logic [63:0] p5;
    int          bt;
    n = 64'(n_in);
    if (n > 64'd510) begin
      n = 64'd510;
    end
    if (n * 64'd100000 <= 64'd2062950) begin
      return (n * 64'd25 * Q31_ONE) / 64'd164730;
    end
    a  = 64'd100 * n + 64'd2805;
    u2 = (a * a * Q31_ONE) / B_SQ;
    r  = 64'd0;
    if (u2 >= Q31_ONE) begin
      r  = Q31_ONE;
      u2 = Q31_ONE;
    end else begin
      // fifth root by bitwise search
      for (bt = 30; bt >= 0; bt--) begin
        c  = r | (64'd1 << bt);
        p2 = (c * c) >> 31;
        p5 = (((p2 * p2) >> 31) * c) >> 31;
        if (p5 <= u2) begin
          r = c;
        end
      end
    end
    return (u2 * r) >> 31;
  endfunction

  function automatic logic [63:0] mbd_lin_entry(input int unsigned k, input int unsigned lb);
    logic [63:0] full;
    full = (64'd1 << lb) - 64'd1;
    return (mbd_decode_q31(2 * k) * full + (Q31_ONE >> 1)) >> 31;
  endfunction

  function automatic logic [63:0] mbd_thr_entry(input int unsigned k, input int unsigned lb);
    logic [63:0] full;
    full = (64'd1 << lb) - 64'd1;
    if (k == 0) begin
      return 64'd0;
    end
    return (mbd_decode_q31(2 * k - 1) * 64'd4 * full + Q31_ONE - 64'd1) >> 31;
  endfunction

endpackage

FILE: design/mbd_ram.sv
// generic synchronous ram, one write port and two registered read ports
// no dependencies
module mbd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] ra_addr_i,
  output logic [WIDTH-1:0]         ra_data_o,
  input  logic [$clog2(DEPTH)-1:0] rb_addr_i,
  output logic [WIDTH-1:0]         rb_data_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    ra_data_o <= mem[ra_addr_i];
    rb_data_o <= mem[rb_addr_i];
  end

endmodule

FILE: design/mbd_cfg.sv
// apb register file: image width, image height, srgb mode
// depends on mbd_pkg
module mbd_cfg
  import mbd_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [MBD_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  output mbd_cfg_t              cfg_o
);

  logic [12:0] width_q;
  logic [12:0] height_q;
  logic        srgb_q;
  logic        wr;
  logic [1:0]  reg_idx;

  assign wr      = psel && penable && pwrite;
  assign reg_idx = paddr[3:2];
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= 13'd1;
      height_q <= 13'd1;
      srgb_q   <= 1'b0;
    end else if (wr) begin
      case (reg_idx)
        REG_WIDTH:  width_q  <= pwdata[12:0];
        REG_HEIGHT: height_q <= pwdata[12:0];
        REG_SRGB:   srgb_q   <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_WIDTH:  prdata = {19'd0, width_q};
      REG_HEIGHT: prdata = {19'd0, height_q};
      REG_SRGB:   prdata = {31'd0, srgb_q};
      default:    prdata = 32'd0;
    endcase
  end

  // any write to a real register restarts the image
  assign cfg_o.width  = width_q;
  assign cfg_o.height = height_q;
  assign cfg_o.srgb   = srgb_q;
  assign cfg_o.clear  = wr && (reg_idx == REG_WIDTH || reg_idx == REG_HEIGHT ||
                               reg_idx == REG_SRGB);

endmodule

FILE: design/mbd_combine.sv
// 2x2 rgba average. srgb rgb: linearize/sum stage, then threshold search to srgb
// other rgb, alpha: rounded mean; depends on mbd_pkg for the table functions
module mbd_combine
  import mbd_pkg::*;
#(
  parameter int LINEAR_BITS = MBD_LINEAR_BITS
) (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic        srgb_i,
  input  logic [31:0] tl_i,
  input  logic [31:0] tr_i,
  input  logic [31:0] bl_i,
  input  logic [31:0] br_i,
  output logic [31:0] q_o
);

  localparam int LB = LINEAR_BITS;
  localparam int SW = LINEAR_BITS + 2;

  logic [LB-1:0] lin_tab [256];
  logic [SW-1:0] thr_tab [256];

  for (genvar k = 0; k < 256; k++) begin : g_tab
    localparam logic [63:0] LV = mbd_lin_entry(k, LB);
    localparam logic [63:0] TV = mbd_thr_entry(k, LB);
    assign lin_tab[k] = LV[LB-1:0];
    assign thr_tab[k] = TV[SW-1:0];
  end

  logic [SW-1:0] sum_q [3];
  logic [9:0]    asum_q;
  logic          srgb_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      srgb_q <= srgb_i;
      for (int c = 0; c < 3; c++) begin
        if (srgb_i) begin
          sum_q[c] <= SW'(lin_tab[tl_i[8*c +: 8]]) + SW'(lin_tab[tr_i[8*c +: 8]]) +
                      SW'(lin_tab[bl_i[8*c +: 8]]) + SW'(lin_tab[br_i[8*c +: 8]]);
        end else begin
          sum_q[c] <= SW'(10'(tl_i[8*c +: 8]) + 10'(tr_i[8*c +: 8]) +
                          10'(bl_i[8*c +: 8]) + 10'(br_i[8*c +: 8]));
        end
      end
      asum_q <= 10'(tl_i[31:24]) + 10'(tr_i[31:24]) + 10'(bl_i[31:24]) + 10'(br_i[31:24]);
    end
  end

  always_comb begin
    logic [7:0] k;
    logic [7:0] cand;
    logic [9:0] rs;
    q_o  = 32'd0;
    k    = 8'd0;
    cand = 8'd0;
    rs   = 10'd0;
    for (int c = 0; c < 3; c++) begin
      if (srgb_q) begin
        // thresholds are monotone, so the count is the last code met
        k = 8'd0;
        for (int b = 7; b >= 0; b--) begin
          cand = k | (8'd1 << b);
          if (thr_tab[cand] <= sum_q[c]) begin
            k = cand;
          end
        end
        q_o[8*c +: 8] = k;
      end else begin
        rs = sum_q[c][9:0] + 10'd2;
        q_o[8*c +: 8] = rs[9:2];
      end
    end
    rs = asum_q + 10'd2;
    q_o[31:24] = rs[9:2];
  end

endmodule

FILE: design/mipmap_box_downsampler.sv
// walker: an item that completes no block occupies the level walker only in the row read state
// after acceptance; each level result passes the row read, linearize/sum and search states and
// is registered at the output, where a stalled output holds the walker in the search state.
// throughput: one item per cycle while no block completes; an item with results holds the walker
// until its last result fires, bounded by the row-store read-combine-write chain per level.
// reset: level counters and control cleared; row store and left holds are not cleared.
module mipmap_box_downsampler
  import mbd_pkg::*;
#(
  parameter int MAX_DIM     = MBD_MAX_DIM,
  parameter int LINEAR_BITS = MBD_LINEAR_BITS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [MBD_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [7:0]            red_in_i,
  input  logic [7:0]            green_in_i,
  input  logic [7:0]            blue_in_i,
  input  logic [7:0]            alpha_in_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [3:0]            mip_level_o,
  output logic [10:0]           pos_x_o,
  output logic [10:0]           pos_y_o,
  output logic [7:0]            red_out_o,
  output logic [7:0]            green_out_o,
  output logic [7:0]            blue_out_o,
  output logic [7:0]            alpha_out_o,
  output logic                  run_last_o,
  output logic                  chain_done_o
);

  localparam int NLEV      = $clog2(MAX_DIM) + 1;
  localparam int IW        = $clog2(NLEV);
  localparam int LW        = $clog2(NLEV + 1);
  localparam int CW        = $clog2(MAX_DIM);
  localparam int DW        = $clog2(MAX_DIM + 1);
  localparam int ROW_DEPTH = 2 * MAX_DIM + 16;
  localparam int AW        = $clog2(ROW_DEPTH);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RD   = 2'd1;
  localparam logic [1:0] ST_LIN  = 2'd2;
  localparam logic [1:0] ST_CNT  = 2'd3;

  mbd_cfg_t cfg;

  mbd_cfg u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .cfg_o  (cfg)
  );

  function automatic logic [DW-1:0] dim_at(input logic [DW-1:0] d, input logic [LW-1:0] s);
    logic [DW-1:0] v;
    v = d >> s;
    return (v == '0) ? DW'(1) : v;
  endfunction

  function automatic logic [DW-1:0] clamp_dim(input logic [12:0] v);
    if (v == 13'd0) begin
      return DW'(1);
    end
    if (32'(v) > MAX_DIM) begin
      return DW'(MAX_DIM);
    end
    return DW'(v);
  endfunction

  logic [DW-1:0] w_c;
  logic [DW-1:0] h_c;
  logic [DW-1:0] m_c;
  logic [LW-1:0] levels;

  assign w_c = clamp_dim(cfg.width);
  assign h_c = clamp_dim(cfg.height);
  assign m_c = (w_c > h_c) ? w_c : h_c;

  always_comb begin
    levels = LW'(1);
    for (int i = 1; i < DW; i++) begin
      if (m_c[i]) begin
        levels = LW'(i + 1);
      end
    end
  end

  // walker state
  logic [1:0]    st_q, st_d;
  logic [LW-1:0] lvl_q;
  logic [IW-1:0] li;
  logic [31:0]   p_q;
  logic [CW-1:0] x_q, y_q;
  logic [AW-1:0] base_q;
  logic [31:0]   bl_q;
  logic          hp1_q;
  logic          tlsel_q;

  logic [CW-1:0] col_q [NLEV];
  logic [CW-1:0] row_q [NLEV];
  logic [31:0]   hold_q [NLEV];

  logic [DW-1:0] wp, hp, wl, hl;
  logic [AW-1:0] idx;
  logic          rd_done;
  logic          free;
  logic          in_acc;
  logic          out_free;
  logic          fire;
  logic          nxt_ok;
  logic          done_next;
  logic [CW-1:0] px, py;

  assign li  = lvl_q[IW-1:0];
  assign wp  = dim_at(w_c, LW'(lvl_q - LW'(1)));
  assign hp  = dim_at(h_c, LW'(lvl_q - LW'(1)));
  assign wl  = dim_at(w_c, lvl_q);
  assign hl  = dim_at(h_c, lvl_q);
  assign idx = base_q + AW'(x_q);
  assign px  = col_q[li];
  assign py  = row_q[li];

  assign rd_done   = (wp == DW'(1) || x_q[0]) && (hp == DW'(1) || y_q[0]);
  assign free      = (st_q == ST_IDLE) || (st_q == ST_RD && !rd_done);
  assign in_stall_o = !free;
  assign in_acc    = in_valid_i && free;
  assign out_free  = !out_valid_o || !out_stall_i;
  assign fire      = (st_q == ST_CNT) && out_free;
  assign nxt_ok    = (LW'(lvl_q + LW'(1)) < levels);
  assign done_next = (wl == DW'(1) || px[0]) && (hl == DW'(1) || py[0]);

  // row store
  logic          ram_we;
  logic [31:0]   ram_a, ram_b;

  assign ram_we = (st_q == ST_RD) && (hp != DW'(1)) && !y_q[0];

  mbd_ram #(
    .WIDTH(32),
    .DEPTH(ROW_DEPTH)
  ) u_row_ram (
    .clk_i    (clk_i),
    .we_i     (ram_we),
    .waddr_i  (idx),
    .wdata_i  (p_q),
    .ra_addr_i(idx),
    .ra_data_o(ram_a),
    .rb_addr_i(AW'(idx - AW'(1))),
    .rb_data_o(ram_b)
  );

  logic [31:0] tr_c, tl_c, q_c;

  assign tr_c = hp1_q ? p_q : ram_a;
  assign tl_c = hp1_q ? bl_q : (tlsel_q ? tr_c : ram_b);

  mbd_combine #(
    .LINEAR_BITS(LINEAR_BITS)
  ) u_combine (
    .clk_i (clk_i),
    .en_i  (st_q == ST_LIN),
    .srgb_i(cfg.srgb),
    .tl_i  (tl_c),
    .tr_i  (tr_c),
    .bl_i  (bl_q),
    .br_i  (p_q),
    .q_o   (q_c)
  );

  always_comb begin
    st_d = st_q;
    case (st_q)
      ST_IDLE: begin
        if (in_acc) begin
          st_d = (levels > LW'(1)) ? ST_RD : ST_IDLE;
        end
      end
      ST_RD: begin
        if (rd_done) begin
          st_d = ST_LIN;
        end else if (in_acc) begin
          st_d = (levels > LW'(1)) ? ST_RD : ST_IDLE;
        end else begin
          st_d = ST_IDLE;
        end
      end
      ST_LIN: st_d = ST_CNT;
      ST_CNT: begin
        if (out_free) begin
          st_d = nxt_ok ? ST_RD : ST_IDLE;
        end
      end
      default: st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_IDLE;
    end else begin
      st_q <= st_d;
    end
  end

  // payload of the walker
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      p_q    <= {alpha_in_i, blue_in_i, green_in_i, red_in_i};
      x_q    <= col_q[0];
      y_q    <= row_q[0];
      lvl_q  <= LW'(1);
      base_q <= '0;
    end else if (fire) begin
      p_q    <= q_c;
      x_q    <= px;
      y_q    <= py;
      lvl_q  <= LW'(lvl_q + LW'(1));
      base_q <= AW'(base_q + AW'(wp));
    end
    if (st_q == ST_RD) begin
      bl_q    <= (wp == DW'(1)) ? p_q : hold_q[li];
      hp1_q   <= (hp == DW'(1));
      tlsel_q <= (wp == DW'(1)) || (idx == '0);
      if (!x_q[0]) begin
        hold_q[li] <= p_q;
      end
    end
  end

  // level position counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NLEV; i++) begin
        col_q[i] <= '0;
        row_q[i] <= '0;
      end
    end else if (cfg.clear) begin
      for (int i = 0; i < NLEV; i++) begin
        col_q[i] <= '0;
        row_q[i] <= '0;
      end
    end else begin
      for (int i = 0; i < NLEV; i++) begin
        if ((in_acc && i == 0) || (fire && li == IW'(i))) begin
          if (DW'(col_q[i]) + DW'(1) >= dim_at(w_c, LW'(i))) begin
            col_q[i] <= '0;
            if (DW'(row_q[i]) + DW'(1) >= dim_at(h_c, LW'(i))) begin
              row_q[i] <= '0;
            end else begin
              row_q[i] <= CW'(row_q[i] + CW'(1));
            end
          end else begin
            col_q[i] <= CW'(col_q[i] + CW'(1));
          end
        end
      end
    end
  end

  // output register
  logic ov_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (fire) begin
      ov_q <= 1'b1;
    end else if (!out_stall_i) begin
      ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      mip_level_o  <= 4'(lvl_q);
      pos_x_o      <= 11'(px);
      pos_y_o      <= 11'(py);
      red_out_o    <= q_c[7:0];
      green_out_o  <= q_c[15:8];
      blue_out_o   <= q_c[23:16];
      alpha_out_o  <= q_c[31:24];
      run_last_o   <= !(nxt_ok && done_next);
      chain_done_o <= !nxt_ok;
    end
  end

  assign out_valid_o = ov_q;

  a_acc_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (st_q == ST_RD || st_q == ST_IDLE))
    else $error("walker not in read or idle after request");

  a_lin_after_rd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_LIN) |-> ($past(st_q) == ST_RD))
    else $error("combine stage entered without row read");

  a_done_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && chain_done_o) |-> run_last_o)
    else $error("chain end not marked as last of run");

  a_level_nz: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (mip_level_o != 4'd0))
    else $error("result carries base level");

  a_col_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_IDLE) |-> (DW'(col_q[0]) < w_c || $past(cfg.width) != cfg.width))
    else $error("base column counter out of range");

endmodule
